// ----- src/gnce_pkg.sv -----
// Shared package for the cubic grid neighbour enumerator.
// Holds field widths, the register map and the offset code type.
// No dependencies.
package gnce_pkg;

   // Field widths fixed by the interface
   localparam int INDEX_W      = 18;
   localparam int TDATA_W      = 24;
   localparam int SIDE_CFG_W   = 7;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 1;

   // Largest side the register can hold, and the default saturation point
   localparam int SIDE_CFG_MAX = (1 << SIDE_CFG_W) - 1;
   localparam int MAX_SIDE_DEF = 64;

   // Reset value of the side register
   localparam logic [SIDE_CFG_W-1:0] GRID_SIDE_RESET = SIDE_CFG_W'(8);

   // Register map (byte addresses)
   localparam logic [CSR_ADDR_W-1:0] ADDR_GRID_SIDE = CSR_ADDR_W'(0);

   // Per-axis offset code: -1, 0, +1
   typedef enum logic [1:0] {
      OFS_NEG  = 2'd0,
      OFS_ZERO = 2'd1,
      OFS_POS  = 2'd2
   } gnce_offset_type;

endpackage

// ----- src/grid_neighbor_cell_enumerator_top.sv -----
// Top level of the cubic grid neighbour enumerator: side register, front stage,
// two divider pipelines and the neighbour walker.
// Depends on gnce_pkg, gnce_div_pipe and gnce_walk.
//
//   channel   direction  carries
//   req_      in         cell word: tdata[17:0] cell_index
//   rsp_      out        neighbour word: tdata[17:0] neighbor_index, tlast last_neighbor
//   csr_      in/out     APB register port, grid_side at byte address 0
//
// The walker steps a cell's offsets in order from (-1,-1,-1) up to its last in-grid
// neighbour, at most 27 of them; a cell with no neighbours gives no word. The walker bounds
// the rate; the front stage and 18-stage dividers accept a word every cycle unless stalled.
// Leading offsets that miss the grid delay a cell's first rsp_ word.
// Reset is synchronous; it empties every stage and sets grid_side to 8.
// A stall on rsp_ holds the result register and backs up through the pipeline.
module grid_neighbor_cell_enumerator_top #(
   parameter int MAX_SIDE = gnce_pkg::MAX_SIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // cell word: [17:0] cell_index
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gnce_pkg::TDATA_W-1:0]    req_tdata,
   // neighbour word: [17:0] neighbor_index
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gnce_pkg::TDATA_W-1:0]    rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gnce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [gnce_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [gnce_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int IW      = gnce_pkg::INDEX_W;
   localparam int EFF_MAX = (MAX_SIDE < gnce_pkg::SIDE_CFG_MAX) ? MAX_SIDE
                                                                : gnce_pkg::SIDE_CFG_MAX;
   localparam int SW      = $clog2(EFF_MAX + 1);
   localparam int CW      = $clog2(EFF_MAX);
   localparam int PW1     = IW + 3 * SW;
   localparam int PW2     = PW1 + CW;

   logic [gnce_pkg::SIDE_CFG_W-1:0] grid_side_ff, grid_side_in;
   logic                            csr_write;

   logic          s0_valid_ff, s0_valid_in;
   logic [IW-1:0] s0_idx_ff;
   logic [SW-1:0] s0_side_ff, side_sat;
   logic [2*SW-1:0] s0_sq;

   logic           d1_in_ready, d1_valid, d1_ready;
   logic [IW-1:0]  d1_quot;
   logic [SW-1:0]  d1_rem;
   logic [PW1-1:0] d1_pay;

   logic           d2_valid, d2_ready;
   logic [IW-1:0]  d2_quot;
   logic [SW-1:0]  d2_rem;
   logic [PW2-1:0] d2_pay;

   logic [SW-1:0]   w_side;
   logic [2*SW-1:0] w_sq;
   logic [IW-1:0]   w_idx;
   logic [CW-1:0]   w_x;
   logic            w_empty;
   logic [IW-1:0]   w_rsp_index;

   // Register port: write on the access cycle, read back the side
   always_comb begin
      csr_write    = csr_psel && csr_penable && csr_pwrite && csr_pready;
      grid_side_in = grid_side_ff;
      if (csr_write && (csr_paddr == gnce_pkg::ADDR_GRID_SIDE)) begin
         grid_side_in = csr_pwdata[gnce_pkg::SIDE_CFG_W-1:0];
      end
      csr_prdata = '0;
      if (csr_paddr == gnce_pkg::ADDR_GRID_SIDE) begin
         csr_prdata = gnce_pkg::CSR_DATA_W'(grid_side_ff);
      end
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff <= gnce_pkg::GRID_SIDE_RESET;
      end else begin
         grid_side_ff <= grid_side_in;
      end
   end

   // Front stage: capture the index with the saturated side
   always_comb begin
      side_sat    = (grid_side_ff > gnce_pkg::SIDE_CFG_W'(EFF_MAX)) ? SW'(EFF_MAX)
                                                                      : SW'(grid_side_ff);
      req_tready  = !s0_valid_ff || d1_in_ready;
      s0_valid_in = req_tready ? req_tvalid : s0_valid_ff;
      s0_sq       = (2*SW)'(s0_side_ff) * (2*SW)'(s0_side_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s0_idx_ff  <= req_tdata[IW-1:0];
         s0_side_ff <= side_sat;
      end
   end

   // index / side: remainder is x
   gnce_div_pipe #(.DW(IW), .SW(SW), .PW(PW1)) u_div_x (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s0_valid_ff),
      .in_ready      (d1_in_ready),
      .in_dividend   (s0_idx_ff),
      .in_divisor    (s0_side_ff),
      .in_payload    ({s0_idx_ff, s0_sq, s0_side_ff}),
      .out_valid     (d1_valid),
      .out_ready     (d1_ready),
      .out_quotient  (d1_quot),
      .out_remainder (d1_rem),
      .out_payload   (d1_pay)
   );

   // (index / side) / side: remainder is y, quotient is z
   gnce_div_pipe #(.DW(IW), .SW(SW), .PW(PW2)) u_div_yz (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (d1_valid),
      .in_ready      (d1_ready),
      .in_dividend   (d1_quot),
      .in_divisor    (d1_pay[SW-1:0]),
      .in_payload    ({CW'(d1_rem), d1_pay}),
      .out_valid     (d2_valid),
      .out_ready     (d2_ready),
      .out_quotient  (d2_quot),
      .out_remainder (d2_rem),
      .out_payload   (d2_pay)
   );

   // Unpack and drop cells outside the grid or on a degenerate side
   always_comb begin
      w_side  = d2_pay[SW-1:0];
      w_sq    = d2_pay[3*SW-1:SW];
      w_idx   = d2_pay[PW1-1:3*SW];
      w_x     = d2_pay[PW2-1:PW1];
      w_empty = (w_side < SW'(2)) || (d2_quot >= IW'(w_side));
   end

   gnce_walk #(.SW(SW), .CW(CW)) u_walk (
      .clock      (clock),
      .reset      (reset),
      .cell_valid (d2_valid),
      .cell_ready (d2_ready),
      .cell_index (w_idx),
      .cell_sq    (w_sq),
      .cell_side  (w_side),
      .cell_x     (w_x),
      .cell_y     (CW'(d2_rem)),
      .cell_z     (CW'(d2_quot)),
      .cell_empty (w_empty),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_index  (w_rsp_index),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {{(gnce_pkg::TDATA_W - IW){1'b0}}, w_rsp_index};

endmodule

// ----- src/gnce_div_pipe.sv -----
// Pipelined restoring divider: one quotient bit per register stage.
// Carries an opaque payload alongside each word; stages collapse bubbles.
// Depends on nothing but its parameters.
module gnce_div_pipe #(
   parameter int DW = 18,
   parameter int SW = 7,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [DW-1:0] in_dividend,
   input  logic [SW-1:0] in_divisor,
   input  logic [PW-1:0] in_payload,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [DW-1:0] out_quotient,
   output logic [SW-1:0] out_remainder,
   output logic [PW-1:0] out_payload
);

   logic [DW-1:0] valid_ff;
   logic [DW-1:0] stage_ready;
   logic [DW-1:0] src_valid;
   logic [DW-1:0] dvd_ff [DW];
   logic [SW-1:0] rem_ff [DW];
   logic [SW-1:0] dvs_ff [DW];
   logic [PW-1:0] pay_ff [DW];
   logic [DW-1:0] dvd_in [DW];
   logic [SW-1:0] rem_in [DW];
   logic [SW-1:0] dvs_in [DW];
   logic [PW-1:0] pay_in [DW];

   // Ready ripples back from the output: a stage moves when empty or draining
   for (genvar g = 0; g < DW; g++) begin : g_ready
      if (g == DW - 1) begin : g_last
         assign stage_ready[g] = !valid_ff[g] || out_ready;
      end else begin : g_mid
         assign stage_ready[g] = !valid_ff[g] || stage_ready[g+1];
      end
   end

   // One trial subtraction per stage; dividend bits shift out, quotient bits in
   always_comb begin
      logic [SW:0]   trial;
      logic [SW:0]   diff;
      logic          fits;
      logic [DW-1:0] s_dvd;
      logic [SW-1:0] s_rem;
      logic [SW-1:0] s_dvs;
      for (int i = 0; i < DW; i++) begin
         if (i == 0) begin
            src_valid[i] = in_valid;
            s_dvd        = in_dividend;
            s_rem        = '0;
            s_dvs        = in_divisor;
            pay_in[i]    = in_payload;
         end else begin
            src_valid[i] = valid_ff[i-1];
            s_dvd        = dvd_ff[i-1];
            s_rem        = rem_ff[i-1];
            s_dvs        = dvs_ff[i-1];
            pay_in[i]    = pay_ff[i-1];
         end
         trial     = {s_rem, s_dvd[DW-1]};
         diff      = trial - {1'b0, s_dvs};
         fits      = trial >= {1'b0, s_dvs};
         rem_in[i] = fits ? diff[SW-1:0] : trial[SW-1:0];
         dvd_in[i] = {s_dvd[DW-2:0], fits};
         dvs_in[i] = s_dvs;
      end
   end

   // Stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < DW; i++) begin
            if (stage_ready[i]) begin
               valid_ff[i] <= src_valid[i];
            end
         end
      end
   end

   // Stage payload: load only when a word moves in
   always_ff @(posedge clock) begin
      for (int i = 0; i < DW; i++) begin
         if (stage_ready[i] && src_valid[i]) begin
            dvd_ff[i] <= dvd_in[i];
            rem_ff[i] <= rem_in[i];
            dvs_ff[i] <= dvs_in[i];
            pay_ff[i] <= pay_in[i];
         end
      end
   end

   assign in_ready      = stage_ready[0];
   assign out_valid     = valid_ff[DW-1];
   assign out_quotient  = dvd_ff[DW-1];
   assign out_remainder = rem_ff[DW-1];
   assign out_payload   = pay_ff[DW-1];

endmodule

// ----- src/gnce_walk.sv -----
// Neighbour walker: steps one cell's offsets in walk order, one per cycle unless stalled,
// up to its last in-grid neighbour, and drives the result register. Depends on gnce_pkg.
module gnce_walk #(
   parameter int SW = 7,
   parameter int CW = 6
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cell_valid,
   output logic                         cell_ready,
   input  logic [gnce_pkg::INDEX_W-1:0] cell_index,
   input  logic [2*SW-1:0]              cell_sq,
   input  logic [SW-1:0]                cell_side,
   input  logic [CW-1:0]                cell_x,
   input  logic [CW-1:0]                cell_y,
   input  logic [CW-1:0]                cell_z,
   input  logic                         cell_empty,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [gnce_pkg::INDEX_W-1:0] rsp_index,
   output logic                         rsp_last
);

   localparam int IW = gnce_pkg::INDEX_W;

   logic                      busy_ff, busy_in;
   logic [IW-1:0]             idx_ff;
   logic [2*SW-1:0]           sq_ff;
   logic [SW-1:0]             side_ff;
   logic [CW-1:0]             x_ff, y_ff, z_ff;
   gnce_pkg::gnce_offset_type cx_ff, cy_ff, cz_ff, cx_in, cy_in, cz_in;
   gnce_pkg::gnce_offset_type lx_ff, ly_ff, lz_ff, lx_in, ly_in, lz_in;
   logic                      out_valid_ff, out_valid_in;
   logic [IW-1:0]             out_index_ff, out_index_in;
   logic                      out_last_ff;

   logic slot_free, step, at_last, centre, inside_grid, emit, load;

   // Is coordinate plus offset still inside the grid
   function automatic logic axis_ok(input gnce_pkg::gnce_offset_type code,
                                    input logic [CW-1:0] c, input logic [SW-1:0] s);
      logic [SW:0] up;
      up = (SW+1)'(c) + (SW+1)'(1);
      case (code)
         gnce_pkg::OFS_NEG:  return c != '0;
         gnce_pkg::OFS_ZERO: return 1'b1;
         gnce_pkg::OFS_POS:  return up < (SW+1)'(s);
         default:            return 1'b0;
      endcase
   endfunction

   // Largest offset along an axis that stays inside
   function automatic gnce_pkg::gnce_offset_type top_code(input logic [CW-1:0] c,
                                                          input logic [SW-1:0] s);
      logic [SW:0] up;
      up = (SW+1)'(c) + (SW+1)'(1);
      return (up < (SW+1)'(s)) ? gnce_pkg::OFS_POS : gnce_pkg::OFS_ZERO;
   endfunction

   // Signed step along an axis, modulo 2^IW
   function automatic logic [IW-1:0] term(input gnce_pkg::gnce_offset_type code,
                                          input logic [IW-1:0] mag);
      case (code)
         gnce_pkg::OFS_NEG: return IW'(0) - mag;
         gnce_pkg::OFS_POS: return mag;
         default:           return '0;
      endcase
   endfunction

   function automatic gnce_pkg::gnce_offset_type next_code(
      input gnce_pkg::gnce_offset_type code);
      case (code)
         gnce_pkg::OFS_NEG:  return gnce_pkg::OFS_ZERO;
         gnce_pkg::OFS_ZERO: return gnce_pkg::OFS_POS;
         default:            return gnce_pkg::OFS_NEG;
      endcase
   endfunction

   // Step control and offset counters
   always_comb begin
      slot_free   = !out_valid_ff || rsp_ready;
      step        = busy_ff && slot_free;
      at_last     = (cx_ff == lx_ff) && (cy_ff == ly_ff) && (cz_ff == lz_ff);
      centre      = (cx_ff == gnce_pkg::OFS_ZERO) && (cy_ff == gnce_pkg::OFS_ZERO) &&
                    (cz_ff == gnce_pkg::OFS_ZERO);
      inside_grid = axis_ok(cx_ff, x_ff, side_ff) && axis_ok(cy_ff, y_ff, side_ff) &&
                    axis_ok(cz_ff, z_ff, side_ff);
      emit        = step && inside_grid && !centre;
      cell_ready  = !busy_ff || (step && at_last);
      load        = cell_valid && cell_ready && !cell_empty;

      // last neighbour in walk order; if that is the centre, fall back one z step
      lx_in = top_code(cell_x, cell_side);
      ly_in = top_code(cell_y, cell_side);
      lz_in = top_code(cell_z, cell_side);
      if ((lx_in == gnce_pkg::OFS_ZERO) && (ly_in == gnce_pkg::OFS_ZERO) &&
          (lz_in == gnce_pkg::OFS_ZERO)) begin
         lz_in = gnce_pkg::OFS_NEG;
      end

      // advance z fastest, carry into y then x
      cz_in = cz_ff;
      cy_in = cy_ff;
      cx_in = cx_ff;
      if (load) begin
         cz_in = gnce_pkg::OFS_NEG;
         cy_in = gnce_pkg::OFS_NEG;
         cx_in = gnce_pkg::OFS_NEG;
      end else if (step) begin
         cz_in = next_code(cz_ff);
         if (cz_ff == gnce_pkg::OFS_POS) begin
            cy_in = next_code(cy_ff);
            if (cy_ff == gnce_pkg::OFS_POS) begin
               cx_in = next_code(cx_ff);
            end
         end
      end

      busy_in = busy_ff;
      if (load) begin
         busy_in = 1'b1;
      end else if (step && at_last) begin
         busy_in = 1'b0;
      end

      // result register: fill on emit, drain when taken
      out_index_in = idx_ff + term(cx_ff, IW'(1)) + term(cy_ff, IW'(side_ff)) +
                     term(cz_ff, IW'(sq_ff));
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Cell and counter registers
   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      cz_ff <= cz_in;
      if (load) begin
         idx_ff  <= cell_index;
         sq_ff   <= cell_sq;
         side_ff <= cell_side;
         x_ff    <= cell_x;
         y_ff    <= cell_y;
         z_ff    <= cell_z;
         lx_ff   <= lx_in;
         ly_ff   <= ly_in;
         lz_ff   <= lz_in;
      end
      if (emit) begin
         out_index_ff <= out_index_in;
         out_last_ff  <= at_last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_index = out_index_ff;
   assign rsp_last  = out_last_ff;

endmodule

// ----- src/gnce_checker.sv -----
// Port-level checks for the neighbour enumerator, bound to the top level.
// Depends on gnce_pkg and grid_neighbor_cell_enumerator_top.
module gnce_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [gnce_pkg::TDATA_W-1:0]    req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gnce_pkg::TDATA_W-1:0]    rsp_tdata,
   input logic                            rsp_tlast,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [gnce_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [gnce_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [gnce_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                            csr_pready
);

   localparam int SCW = gnce_pkg::SIDE_CFG_W;

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Reset empties the result register
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Reset empties the front stage, so a word can enter at once
   a_req_reset: assert property (@(posedge clock) reset |=> req_tready)
      else $error("input not ready after reset");

   // A side write reads back on the next cycle
   a_side_readback: assert property (@(posedge clock) disable iff (reset)
      $past(csr_psel && csr_penable && csr_pwrite && csr_pready &&
            (csr_paddr == gnce_pkg::ADDR_GRID_SIDE)) && !$past(reset) &&
      (csr_paddr == gnce_pkg::ADDR_GRID_SIDE)
      |-> csr_prdata == gnce_pkg::CSR_DATA_W'($past(csr_pwdata[SCW-1:0])))
      else $error("side register did not read back the written value");

endmodule

bind grid_neighbor_cell_enumerator_top gnce_checker u_gnce_checker (.*);
